/* rtl/core/ulr_pkg.sv */
// Shared types and constants for the lite UART register block.
// Holds the FIFO sizing, the opcode and register codes, and the control structs.
// No dependencies.
package ulr_pkg;

	localparam int FIFO_DEPTH = 16;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int SUM_W      = PTR_W + 1;

	localparam int DATA_W      = 32;
	localparam int BYTE_W      = 8;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 48;
	localparam int IN_TUSER_W  = 2;

	typedef enum logic [1:0] {
		OP_BUS_READ    = 2'd0,
		OP_BUS_WRITE   = 2'd1,
		OP_LINE_RX     = 2'd2,
		OP_LINE_TX_REQ = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		REG_RX_DATA = 2'd0,
		REG_TX_DATA = 2'd1,
		REG_STATUS  = 2'd2,
		REG_CONTROL = 2'd3
	} reg_index_t;

	localparam int STAT_RX_VALID = 0;
	localparam int STAT_RX_FULL  = 1;
	localparam int STAT_TX_EMPTY = 2;
	localparam int STAT_TX_FULL  = 3;
	localparam int STAT_IRQ_EN   = 4;
	localparam int STAT_ERR_LSB  = 5;

	localparam int CTRL_TX_RESET = 0;
	localparam int CTRL_RX_RESET = 1;
	localparam int CTRL_IRQ_EN   = 4;

	localparam int ERR_OVERRUN = 0;
	localparam int ERR_FRAME   = 1;
	localparam int ERR_PARITY  = 2;
	localparam int ERR_W       = 3;

	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} fifo_ctrl_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] count_next;
		logic             full;
		logic             empty;
	} fifo_stat_t;

	typedef struct packed {
		opcode_t     opcode;
		reg_index_t  reg_index;
		logic [DATA_W-1:0] write_data;
		logic [BYTE_W-1:0] line_byte;
		logic        line_frame_error;
		logic        line_parity_error;
	} item_t;

endpackage

/* rtl/core/uart_lite_register_block.sv */
// Top level of the lite UART register block: input stage, register decode and result stage.
// Instantiates ulr_fifo for the receive and transmit FIFOs.
// Depends on ulr_pkg and ulr_fifo.
//
// Usage:
// Each input word on the s_axis channel is one event: a bus read, a bus write, a byte
// from the serial line, or a request from the line transmitter, chosen by s_axis_tuser.
// Every event yields exactly one result word on the m_axis channel carrying the read
// data, the byte handed to the transmitter with its valid flag, and the interrupt level
// after the event.
// An accepted word is registered in the input stage, decoded when it advances and applied to the
// FIFOs and flags at that edge, where its result is also loaded into the output register.
// One word is accepted every cycle while the output is not stalled; the FIFO state updates
// once per word.
// Reset clears both FIFOs, the interrupt enable and the error flags and empties both
// pipeline stages.
// When the receiver stalls, the result waits in the output register, one more word is
// held in the input stage, and s_axis_tready drops until the result is taken.
module uart_lite_register_block import ulr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// reg_index[1:0], write_data[33:2], line_byte[41:34], line_frame_error[42],
	// line_parity_error[43], zero fill above
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// opcode[1:0]
	input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// read_data[31:0], tx_valid[32], tx_byte[40:33], irq[41], zero fill above
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	item_t             item_s1;
	logic              valid_s1;
	logic              valid_s2;
	logic              advance;
	logic              s_accept;

	logic [DATA_W-1:0] read_data_s2;
	logic              tx_valid_s2;
	logic [BYTE_W-1:0] tx_byte_s2;
	logic              irq_s2;

	logic              irq_en_q;
	logic              irq_en_next;
	logic [ERR_W-1:0]  err_q;
	logic [ERR_W-1:0]  err_next;

	fifo_ctrl_t        rx_ctrl;
	fifo_ctrl_t        tx_ctrl;
	fifo_stat_t        rx_stat;
	fifo_stat_t        tx_stat;
	logic [BYTE_W-1:0] rx_rdata;
	logic [BYTE_W-1:0] tx_rdata;

	logic [DATA_W-1:0] read_data;
	logic              tx_valid;
	logic [BYTE_W-1:0] tx_byte;
	logic              irq_next;
	logic [DATA_W-1:0] status_word;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= s_accept || (valid_s1 && !advance);
			valid_s2 <= advance || (valid_s2 && !m_axis_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1.opcode            <= opcode_t'(s_axis_tuser[1:0]);
			item_s1.reg_index         <= reg_index_t'(s_axis_tdata[1:0]);
			item_s1.write_data        <= s_axis_tdata[33:2];
			item_s1.line_byte         <= s_axis_tdata[41:34];
			item_s1.line_frame_error  <= s_axis_tdata[42];
			item_s1.line_parity_error <= s_axis_tdata[43];
		end
	end

	ulr_fifo u_rx_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (rx_ctrl),
		.wdata  (item_s1.line_byte),
		.rdata  (rx_rdata),
		.stat   (rx_stat)
	);

	ulr_fifo u_tx_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (tx_ctrl),
		.wdata  (item_s1.write_data[BYTE_W-1:0]),
		.rdata  (tx_rdata),
		.stat   (tx_stat)
	);

	always_comb begin
		status_word                   = '0;
		status_word[STAT_RX_VALID]    = !rx_stat.empty;
		status_word[STAT_RX_FULL]     = rx_stat.full;
		status_word[STAT_TX_EMPTY]    = tx_stat.empty;
		status_word[STAT_TX_FULL]     = tx_stat.full;
		status_word[STAT_IRQ_EN]      = irq_en_q;
		status_word[STAT_ERR_LSB +: ERR_W] = err_q;
	end

	always_comb begin
		rx_ctrl     = '0;
		tx_ctrl     = '0;
		read_data   = '0;
		tx_valid    = 1'b0;
		tx_byte     = '0;
		irq_en_next = irq_en_q;
		err_next    = err_q;
		if (advance) begin
			unique case (item_s1.opcode)
				OP_BUS_READ: begin
					unique case (item_s1.reg_index)
						REG_RX_DATA: begin
							if (!rx_stat.empty) begin
								read_data   = DATA_W'(rx_rdata);
								rx_ctrl.pop = 1'b1;
							end
						end
						REG_STATUS: begin
							read_data = status_word;
							err_next  = '0;
						end
						default: begin
						end
					endcase
				end
				OP_BUS_WRITE: begin
					unique case (item_s1.reg_index)
						REG_TX_DATA: begin
							tx_ctrl.push = 1'b1;
						end
						REG_CONTROL: begin
							tx_ctrl.clear = item_s1.write_data[CTRL_TX_RESET];
							rx_ctrl.clear = item_s1.write_data[CTRL_RX_RESET];
							irq_en_next   = item_s1.write_data[CTRL_IRQ_EN];
						end
						default: begin
						end
					endcase
				end
				OP_LINE_RX: begin
					err_next[ERR_FRAME]  = err_q[ERR_FRAME] | item_s1.line_frame_error;
					err_next[ERR_PARITY] = err_q[ERR_PARITY] | item_s1.line_parity_error;
					if (rx_stat.full) begin
						err_next[ERR_OVERRUN] = 1'b1;
					end else begin
						rx_ctrl.push = 1'b1;
					end
				end
				OP_LINE_TX_REQ: begin
					if (!tx_stat.empty) begin
						tx_valid    = 1'b1;
						tx_byte     = tx_rdata;
						tx_ctrl.pop = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign irq_next = irq_en_next && ((rx_stat.count_next != '0) || (tx_stat.count_next == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_en_q <= 1'b0;
			err_q    <= '0;
		end else begin
			irq_en_q <= irq_en_next;
			err_q    <= err_next;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_s2 <= read_data;
			tx_valid_s2  <= tx_valid;
			tx_byte_s2   <= tx_byte;
			irq_s2       <= irq_next;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {6'd0, irq_s2, tx_byte_s2, tx_valid_s2, read_data_s2};

`ifndef ASSERT_OFF
	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && m_axis_tvalid && !m_axis_tready))
		else $error("input stalled while the output stage could move");

	a_rx_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stat.count <= CNT_W'(FIFO_DEPTH))
		else $error("receive FIFO count exceeds its depth");

	a_tx_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tx_stat.count <= CNT_W'(FIFO_DEPTH))
		else $error("transmit FIFO count exceeds its depth");

	a_tx_word_no_read_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && tx_valid_s2) |-> (read_data_s2 == '0))
		else $error("transmit handoff carries read data");

	a_irq_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && irq_s2) |-> irq_en_q)
		else $error("interrupt raised with interrupt enable clear");

	a_state_moves_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(rx_stat.count) && $stable(tx_stat.count) && $stable(err_q)))
		else $error("register state changed without an item");
`endif

endmodule

/* rtl/core/ulr_fifo.sv */
// Byte FIFO of FIFO_DEPTH entries with head pointer and fill count.
// Push, pop and clear are registered; the head entry is read combinationally.
// Depends on ulr_pkg.
module ulr_fifo import ulr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  fifo_ctrl_t        ctrl,
	input  logic [BYTE_W-1:0] wdata,
	output logic [BYTE_W-1:0] rdata,
	output fifo_stat_t        stat
);

	logic [BYTE_W-1:0] store_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  head_next;
	logic [PTR_W-1:0]  head_inc;
	logic [PTR_W-1:0]  wr_ptr;
	logic [SUM_W-1:0]  wr_sum;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_next;
	logic              full;
	logic              empty;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == CNT_W'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = ctrl.push && !full && !ctrl.clear;
	assign do_pop  = ctrl.pop && !empty && !ctrl.clear;

	assign wr_sum   = SUM_W'(head_q) + SUM_W'(count_q);
	assign wr_ptr   = (wr_sum >= SUM_W'(FIFO_DEPTH)) ? PTR_W'(wr_sum - SUM_W'(FIFO_DEPTH))
	                                                  : PTR_W'(wr_sum);
	assign head_inc = (head_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;

	always_comb begin
		head_next  = head_q;
		count_next = count_q;
		if (ctrl.clear) begin
			head_next  = '0;
			count_next = '0;
		end else if (do_push && !do_pop) begin
			count_next = count_q + 1'b1;
		end else if (do_pop && !do_push) begin
			head_next  = head_inc;
			count_next = count_q - 1'b1;
		end else if (do_pop && do_push) begin
			head_next  = head_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= head_next;
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr] <= wdata;
		end
	end

	assign rdata = store_q[head_q];

	assign stat.count      = count_q;
	assign stat.count_next = count_next;
	assign stat.full       = full;
	assign stat.empty      = empty;

endmodule
